[hw/rtl/itsc_pkg.sv]
// ----------------------------------------------------------------------------
// itsc_pkg: shared types and constants for the identifier token scanner
// Item structs, phase and status codes, character constants and the
// character class functions used by the scan step.
// ----------------------------------------------------------------------------
`default_nettype none

package itsc_pkg;

  // parameter defaults
  localparam int MAX_ANGLE_DEPTH_DEF = 255;
  localparam int POSITION_BITS_DEF   = 16;

  // width of the resume offset on the result item
  localparam int RESUME_W = 16;

  // configuration register indexes
  localparam logic CFG_DELIMITER  = 1'b0;
  localparam logic CFG_IDENT_MODE = 1'b1;

  // scan phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_LEAD  = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;
  localparam logic [1:0] PH_TRAIL = 2'd3;

  // status codes
  localparam logic [2:0] ST_BUSY        = 3'd0;
  localparam logic [2:0] ST_OK          = 3'd1;
  localparam logic [2:0] ST_UNEXP_END   = 3'd2;
  localparam logic [2:0] ST_BAD_START   = 3'd3;
  localparam logic [2:0] ST_MISMATCH    = 3'd4;
  localparam logic [2:0] ST_OVERFLOW    = 3'd5;
  localparam logic [2:0] ST_EXP_IDENT   = 3'd6;

  // character constants
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // input item
  typedef struct packed {
    logic [7:0] char_in;
    logic       scan_start;
  } char_item_t;

  // result item
  typedef struct packed {
    logic                emit_valid;
    logic [7:0]          token_char;
    logic                scan_done;
    logic [2:0]          status;
    logic [RESUME_W-1:0] resume_index;
  } token_item_t;

  // configuration register contents
  typedef struct packed {
    logic [7:0] delimiter;
    logic       identifier_mode;
  } cfg_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // newline is not whitespace here
  function automatic logic is_ws(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
  endfunction

  function automatic logic ident_start(input logic [7:0] c);
    return is_alpha(c) || c == CH_USCORE || c == CH_STAR || c == CH_DOLLAR ||
           is_digit(c);
  endfunction

  function automatic logic single_token(input logic [7:0] c);
    return c == CH_LBRACE || c == CH_RBRACE || c == CH_LBRACK || c == CH_RBRACK ||
           c == CH_COMMA || c == CH_BTICK;
  endfunction

  function automatic logic token_start(input logic [7:0] c);
    return c == CH_QUOTE || c == CH_MINUS || single_token(c) || ident_start(c);
  endfunction

  function automatic logic body_char(input logic [7:0] c);
    return is_alpha(c) || c == CH_USCORE || is_digit(c) || c == CH_DOT ||
           c == CH_QUOTE;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/identifier_token_scanner_core.sv]
// ----------------------------------------------------------------------------
// identifier_token_scanner_core: streaming token scanner
// Takes one expression byte per item and streams out the token text plus
// the scan status and resume offset.
// ----------------------------------------------------------------------------
// Usage:
//   char channel (char_valid, char_stall, char_item): one byte per item;
//   scan_start on the first byte of each new token scan.
//   token channel (token_valid, token_stall, token_item): exactly one result
//   item per accepted byte, in order.
//   cfg port (cfg_we, cfg_index, cfg_data): write the delimiter and the
//   identifier mode only while no byte is in flight.
// Path: a byte accepted goes into the input register, and its result goes
//   into the output register when the scan step advances it.
// Throughput: one byte per cycle while token_stall is low; the scan state
//   is updated by one logic pass between the input and output registers.
// Reset: empties both registers, puts the scanner in idle and clears the
//   configuration to delimiter none, identifier mode off.
// Stall: while token_stall holds, the output item stays put; the input
//   register still takes one more byte, then char_stall rises until the
//   output moves.
// ----------------------------------------------------------------------------
`default_nettype none

module identifier_token_scanner_core
  import itsc_pkg::*;
#(
  parameter int MAX_ANGLE_DEPTH = MAX_ANGLE_DEPTH_DEF,
  parameter int POSITION_BITS   = POSITION_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       char_valid,
  output logic            char_stall,
  input  wire char_item_t char_item,
  output logic            token_valid,
  input  wire logic       token_stall,
  output token_item_t     token_item,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  cfg_t        cfg;
  logic        in_full;
  char_item_t  in_buf;
  logic        advance;
  token_item_t step_result;

  itsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // the buffered byte moves on when the output register is free
  assign advance    = in_full && (!token_valid || !token_stall);
  assign char_stall = in_full && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (char_valid && !char_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      in_buf <= char_item;
    end
  end

  itsc_scan_core #(
    .MAX_ANGLE_DEPTH (MAX_ANGLE_DEPTH),
    .POSITION_BITS   (POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step_en   (advance),
    .char_item (in_buf),
    .cfg       (cfg),
    .result    (step_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (advance) begin
      token_valid <= 1'b1;
    end else if (!token_stall) begin
      token_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      token_item <= step_result;
    end
  end

  // every step lands in the output register
  a_step_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> token_valid)
    else $error("scan step lost its result item");

  // input is held back only by a stalled, full output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> token_valid && token_stall && in_full)
    else $error("input stalled without output back-pressure");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |-> !advance)
    else $error("stalled result item overwritten");

endmodule

`default_nettype wire

[hw/rtl/itsc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// itsc_cfg_regs: configuration registers
// Holds the delimiter byte and the identifier mode flag, written through
// a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module itsc_cfg_regs
  import itsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  output cfg_t            cfg
);

  cfg_t cfg_q;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DELIMITER:  cfg_q.delimiter       <= cfg_data;
        CFG_IDENT_MODE: cfg_q.identifier_mode <= cfg_data[0];
      endcase
    end
  end

  assign cfg = cfg_q;

endmodule

`default_nettype wire

[hw/rtl/itsc_scan_core.sv]
// ----------------------------------------------------------------------------
// itsc_scan_core: per-byte scan step
// Holds the scan state and computes, for one byte, the result item and
// the next state in a single pass of combinational logic.
// ----------------------------------------------------------------------------
`default_nettype none

module itsc_scan_core
  import itsc_pkg::*;
#(
  parameter int MAX_ANGLE_DEPTH = MAX_ANGLE_DEPTH_DEF,
  parameter int POSITION_BITS   = POSITION_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step_en,
  input  wire char_item_t char_item,
  input  wire cfg_t       cfg,
  output token_item_t     result
);

  localparam int AW = $clog2(MAX_ANGLE_DEPTH + 1);
  localparam int PB = POSITION_BITS;
  localparam int RW = PB + 1;
  localparam int EW = (RW > RESUME_W + 1) ? RW : RESUME_W + 1;
  localparam logic [AW-1:0] DEPTH_MAX = AW'(MAX_ANGLE_DEPTH);
  localparam logic [RW-1:0] POS_MAX   = {1'b0, {PB{1'b1}}};
  localparam logic [EW-1:0] RES_MAX   = EW'({1'b0, {RESUME_W{1'b1}}});

  // scan state
  logic [1:0]    phase;
  logic [AW-1:0] angle_depth;
  logic          inside_quotes;
  logic          escape_pending;
  logic          trailing_space_seen;
  logic [PB-1:0] byte_position;

  logic [1:0]    phase_next;
  logic [AW-1:0] angle_depth_next;
  logic          inside_quotes_next;
  logic          escape_pending_next;
  logic          trailing_space_seen_next;
  logic [PB-1:0] byte_position_next;

  // step working signals
  logic [7:0]    c;
  logic [PB-1:0] pos_cur;
  logic          early_done;
  logic          idle_skip;
  logic          stop;
  logic          end_req;
  logic          trail_req;
  logic          emit;
  logic [7:0]    emit_char;
  logic          done;
  logic [2:0]    status;
  logic [RW-1:0] resume_w;
  logic [RW-1:0] resume_pos;
  logic [EW-1:0] resume_ext;

  assign c = char_item.char_in;

  // one scan step
  always_comb begin
    phase_next               = phase;
    angle_depth_next         = angle_depth;
    inside_quotes_next       = inside_quotes;
    escape_pending_next      = escape_pending;
    trailing_space_seen_next = trailing_space_seen;
    pos_cur                  = byte_position;
    early_done               = 1'b0;
    idle_skip                = 1'b0;
    stop                     = 1'b0;
    end_req                  = 1'b0;
    trail_req                = 1'b0;
    emit                     = 1'b0;
    emit_char                = '0;
    done                     = 1'b0;
    status                   = ST_BUSY;
    resume_w                 = '0;

    // a start byte clears the state and opens a new scan
    if (char_item.scan_start) begin
      phase_next               = PH_LEAD;
      angle_depth_next         = '0;
      inside_quotes_next       = 1'b0;
      escape_pending_next      = 1'b0;
      trailing_space_seen_next = 1'b0;
      pos_cur                  = '0;
      if (cfg.identifier_mode && !(ident_start(c) || c == CH_QUOTE)) begin
        early_done = 1'b1;
        done       = 1'b1;
        status     = ST_EXP_IDENT;
        phase_next = PH_IDLE;
      end
    end

    if (!early_done) begin
      unique case (phase_next)
        PH_IDLE: begin
          idle_skip = 1'b1;
        end
        PH_LEAD: begin
          if (!is_ws(c)) begin
            if (!token_start(c)) begin
              done       = 1'b1;
              status     = (c == CH_NUL || c == CH_LF) ? ST_UNEXP_END : ST_BAD_START;
              resume_w   = RW'(pos_cur);
              phase_next = PH_IDLE;
            end else begin
              emit      = 1'b1;
              emit_char = c;
              if (single_token(c)) begin
                done       = 1'b1;
                status     = ST_OK;
                resume_w   = RW'(pos_cur) + RW'(1);
                phase_next = PH_IDLE;
              end else begin
                inside_quotes_next = (c == CH_QUOTE);
                phase_next         = PH_BODY;
              end
            end
          end
        end
        PH_BODY: begin
          if (escape_pending_next) begin
            // escaped byte goes out raw, escaped NUL still ends the body
            escape_pending_next = 1'b0;
            if (c == CH_NUL) begin
              end_req = 1'b1;
            end else begin
              emit      = 1'b1;
              emit_char = c;
            end
          end else if (c == CH_NUL) begin
            end_req = 1'b1;
          end else begin
            priority if (c == CH_LT) begin
              if (angle_depth_next >= DEPTH_MAX) begin
                stop       = 1'b1;
                done       = 1'b1;
                status     = ST_OVERFLOW;
                resume_w   = RW'(pos_cur);
                phase_next = PH_IDLE;
              end else begin
                angle_depth_next = angle_depth_next + AW'(1);
              end
            end else if (c == CH_GT) begin
              if (angle_depth_next == '0) begin
                stop    = 1'b1;
                end_req = 1'b1;
              end else begin
                angle_depth_next = angle_depth_next - AW'(1);
              end
            end else if (c == CH_QUOTE) begin
              inside_quotes_next = ~inside_quotes_next;
            end else if (c == CH_BSLASH) begin
              stop                = 1'b1;
              escape_pending_next = 1'b1;
            end else if (!body_char(c) && !inside_quotes_next) begin
              stop    = 1'b1;
              end_req = 1'b1;
            end else begin
              stop = 1'b0;
            end
            if (!stop) begin
              if (cfg.delimiter != CH_NUL && c == cfg.delimiter) begin
                end_req = 1'b1;
              end else begin
                emit      = 1'b1;
                emit_char = c;
              end
            end
          end
        end
        PH_TRAIL: begin
          trail_req = 1'b1;
        end
      endcase

      // body end: open angles are an error, otherwise look for trailing space
      if (end_req) begin
        if (angle_depth_next != '0) begin
          done       = 1'b1;
          status     = ST_MISMATCH;
          resume_w   = RW'(pos_cur);
          phase_next = PH_IDLE;
        end else begin
          trail_req = 1'b1;
        end
      end

      // trailing whitespace and the colon step-back
      if (trail_req) begin
        if (is_ws(c)) begin
          trailing_space_seen_next = 1'b1;
          phase_next               = PH_TRAIL;
        end else begin
          done       = 1'b1;
          status     = ST_OK;
          phase_next = PH_IDLE;
          if (c == CH_COLON && trailing_space_seen_next && pos_cur != '0) begin
            resume_w = RW'(pos_cur) - RW'(1);
          end else begin
            resume_w = RW'(pos_cur);
          end
        end
      end
    end

    // saturating byte counter
    byte_position_next = pos_cur;
    if (!early_done && !idle_skip && pos_cur != {PB{1'b1}}) begin
      byte_position_next = pos_cur + PB'(1);
    end
  end

  // resume offset saturates at the counter range, then at the field range
  always_comb begin
    resume_pos = (resume_w > POS_MAX) ? POS_MAX : resume_w;
    resume_ext = (EW'(resume_pos) > RES_MAX) ? RES_MAX : EW'(resume_pos);
  end

  assign result.emit_valid   = emit;
  assign result.token_char   = emit_char;
  assign result.scan_done    = done;
  assign result.status       = status;
  assign result.resume_index = resume_ext[RESUME_W-1:0];

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_IDLE;
      angle_depth         <= '0;
      inside_quotes       <= 1'b0;
      escape_pending      <= 1'b0;
      trailing_space_seen <= 1'b0;
      byte_position       <= '0;
    end else if (step_en) begin
      phase               <= phase_next;
      angle_depth         <= angle_depth_next;
      inside_quotes       <= inside_quotes_next;
      escape_pending      <= escape_pending_next;
      trailing_space_seen <= trailing_space_seen_next;
      byte_position       <= byte_position_next;
    end
  end

  // a finished scan leaves the core idle
  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    step_en && result.scan_done |=> phase == PH_IDLE)
    else $error("scan finished but phase is not idle");

  // state only moves on a step
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !step_en |=> $stable(phase) && $stable(byte_position) && $stable(angle_depth))
    else $error("scan state changed without a step");

  // a stray byte outside a scan gives an empty result
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    step_en && phase == PH_IDLE && !char_item.scan_start |->
      !result.emit_valid && !result.scan_done && result.status == ST_BUSY)
    else $error("result produced outside a scan");

endmodule

`default_nettype wire

[test/identifier_token_scanner_core_tb.sv]
// ----------------------------------------------------------------------------
// identifier_token_scanner_core_tb: self-checking bench for the token scanner
// Feeds byte streams of well-formed tokens, broken scans and noise under
// several delimiter and identifier-mode settings, predicts every result
// item with a scan model of its own, and compares the results field by field
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module identifier_token_scanner_core_tb;
  import itsc_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 60;
  localparam int SEG_ITEMS     = 205;
  localparam int DEPTH_LIMIT   = MAX_ANGLE_DEPTH_DEF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_stall;
  char_item_t  char_item = '0;
  logic        token_valid;
  logic        token_stall = 1'b0;
  token_item_t token_item;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = 8'h00;

  identifier_token_scanner_core uut (
    .clk(clk),
    .rst(rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_item(char_item),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token_item(token_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // bytes waiting to be sent and results waiting to arrive
  char_item_t  pending_chars[$];
  token_item_t expected_tokens[$];

  int  err_count = 0;
  int  cycles = 0;
  int  bytes_queued = 0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  hold_requests = 0;
  int  holds_done = 0;
  int  hold_left = 0;
  logic char_taken = 1'b0;
  logic open_scan = 1'b0;

  // scanner state as the bench sees it
  logic [1:0]  scan_phase = PH_IDLE;
  int unsigned angle_level = 0;
  logic        in_quotes = 1'b0;
  logic        escape_armed = 1'b0;
  logic        saw_space = 1'b0;
  logic [15:0] scan_pos = 16'd0;
  logic [7:0]  delim_reg = 8'h00;
  logic        ident_reg = 1'b0;
  token_item_t next_token;

  // character classes
  function automatic logic is_gap(input logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    logic [7:0] low;
    low = c | 8'h20;
    return (c[6] == 1'b1) && low >= 8'h61 && low <= 8'h7A;
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic can_open_ident(input logic [7:0] c);
    return is_letter(c) || is_num(c) || c == CH_USCORE || c == CH_STAR || c == CH_DOLLAR;
  endfunction

  function automatic logic is_lone(input logic [7:0] c);
    case (c)
      CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COMMA, CH_BTICK: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic can_open_token(input logic [7:0] c);
    return can_open_ident(c) || is_lone(c) || c == CH_QUOTE || c == CH_MINUS;
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_letter(c) || is_num(c) || c == CH_USCORE || c == CH_DOT || c == CH_QUOTE;
  endfunction

  // result building blocks
  function automatic void emit_char(input logic [7:0] c);
    next_token.emit_valid = 1'b1;
    next_token.token_char = c;
  endfunction

  function automatic void close_scan(input logic [2:0] st, input logic [16:0] at);
    next_token.scan_done    = 1'b1;
    next_token.status       = st;
    next_token.resume_index = (at > 17'h0FFFF) ? 16'hFFFF : at[15:0];
    scan_phase = PH_IDLE;
  endfunction

  // whitespace after the body, colon after whitespace backs up one
  function automatic void after_body(input logic [7:0] c, input logic [15:0] p);
    if (is_gap(c)) begin
      saw_space  = 1'b1;
      scan_phase = PH_TRAIL;
    end else if (c == CH_COLON && saw_space && p != 16'd0) begin
      close_scan(ST_OK, {1'b0, p} - 17'd1);
    end else begin
      close_scan(ST_OK, {1'b0, p});
    end
  endfunction

  function automatic void end_body(input logic [7:0] c, input logic [15:0] p);
    if (angle_level != 0) close_scan(ST_MISMATCH, {1'b0, p});
    else after_body(c, p);
  endfunction

  // one scan step: the result item caused by one byte
  function automatic token_item_t scan_byte(input char_item_t it);
    logic [7:0]  c;
    logic [15:0] p;
    c = it.char_in;
    next_token = '0;
    if (it.scan_start) begin
      angle_level  = 0;
      in_quotes    = 1'b0;
      escape_armed = 1'b0;
      saw_space    = 1'b0;
      scan_pos     = 16'd0;
      scan_phase   = PH_LEAD;
      if (ident_reg && !(can_open_ident(c) || c == CH_QUOTE)) begin
        close_scan(ST_EXP_IDENT, 17'd0);
        return next_token;
      end
    end
    if (scan_phase == PH_IDLE) return next_token;
    p = scan_pos;
    case (scan_phase)
      PH_LEAD: begin
        if (!is_gap(c)) begin
          if (!can_open_token(c)) begin
            close_scan((c == CH_NUL || c == CH_LF) ? ST_UNEXP_END : ST_BAD_START, {1'b0, p});
          end else begin
            emit_char(c);
            if (is_lone(c)) begin
              close_scan(ST_OK, {1'b0, p} + 17'd1);
            end else begin
              in_quotes  = (c == CH_QUOTE);
              scan_phase = PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        if (escape_armed) begin
          escape_armed = 1'b0;
          if (c == CH_NUL) end_body(c, p);
          else emit_char(c);
        end else if (c == CH_NUL || (c == CH_GT && angle_level == 0)) begin
          end_body(c, p);
        end else if (c == CH_LT && angle_level >= DEPTH_LIMIT) begin
          close_scan(ST_OVERFLOW, {1'b0, p});
        end else if (c == CH_BSLASH) begin
          escape_armed = 1'b1;
        end else if (c != CH_LT && c != CH_GT && !is_word_char(c) && !in_quotes) begin
          end_body(c, p);
        end else begin
          if (c == CH_LT) angle_level++;
          else if (c == CH_GT) angle_level--;
          else if (c == CH_QUOTE) in_quotes = !in_quotes;
          if (delim_reg != 8'h00 && c == delim_reg) end_body(c, p);
          else emit_char(c);
        end
      end
      default: after_body(c, p);
    endcase
    if (scan_pos != 16'hFFFF) scan_pos++;
    return next_token;
  endfunction

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // byte driver
  always @(negedge clk) begin
    char_item_t nxt;
    if (rst) begin
      char_valid <= 1'b0;
      char_item  <= '0;
    end else if (!char_valid || char_taken) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_chars.pop_front();
        char_valid <= 1'b1;
        char_item  <= nxt;
      end else begin
        char_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus long hold-offs on request
  always @(negedge clk) begin
    if (rst) begin
      token_stall <= 1'b0;
    end else if (hold_left != 0) begin
      token_stall <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (holds_done != hold_requests) begin
      token_stall <= 1'b1;
      hold_left   <= HOLD_CYCLES - 1;
      holds_done  <= holds_done + 1;
    end else begin
      token_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      err_count++;
    end
  endfunction

  // monitor: check results against the oldest prediction, then predict
  always @(posedge clk) begin
    token_item_t want;
    if (rst) begin
      char_taken <= 1'b0;
    end else begin
      char_taken <= char_valid && !char_stall;
      if (token_valid && !token_stall) begin
        if (expected_tokens.size() == 0) begin
          $error("token item arrived with nothing expected");
          err_count++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("emit_valid", 16'(want.emit_valid), 16'(token_item.emit_valid));
          check_field("token_char", 16'(want.token_char), 16'(token_item.token_char));
          check_field("scan_done", 16'(want.scan_done), 16'(token_item.scan_done));
          check_field("status", 16'(want.status), 16'(token_item.status));
          check_field("resume_index", want.resume_index, token_item.resume_index);
        end
      end
      if (char_valid && !char_stall) expected_tokens.push_back(scan_byte(char_item));
    end
  end

  // stimulus helpers
  task automatic put_raw(input logic [7:0] c, input logic s);
    char_item_t it;
    it.char_in    = c;
    it.scan_start = s;
    pending_chars.push_back(it);
    bytes_queued++;
  endtask

  task automatic put(input logic [7:0] c);
    put_raw(c, open_scan);
    open_scan = 1'b0;
  endtask

  function automatic logic [7:0] rnd_letter();
    return $urandom_range(1) ? 8'(8'h61 + $urandom_range(25)) : 8'(8'h41 + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rnd_space();
    case ($urandom_range(4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      3: return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] rnd_ident_start();
    case ($urandom_range(7))
      0: return 8'(8'h30 + $urandom_range(9));
      1: return CH_USCORE;
      2: return CH_STAR;
      3: return CH_DOLLAR;
      default: return rnd_letter();
    endcase
  endfunction

  function automatic logic [7:0] rnd_single();
    case ($urandom_range(5))
      0: return CH_LBRACE;
      1: return CH_RBRACE;
      2: return CH_LBRACK;
      3: return CH_RBRACK;
      4: return CH_COMMA;
      default: return CH_BTICK;
    endcase
  endfunction

  task automatic put_body_piece();
    case ($urandom_range(9))
      5: begin
        put(CH_LT);
        put(rnd_ident_start());
        if ($urandom_range(3) != 0) put(CH_GT);
      end
      6: begin
        put(CH_QUOTE);
        repeat ($urandom_range(3)) put(8'($urandom_range(255, 1)));
        put(CH_QUOTE);
      end
      7: begin
        put(CH_BSLASH);
        put(8'($urandom_range(255, 1)));
      end
      8: put(CH_GT);
      9: put(8'($urandom_range(255)));
      default: begin
        case ($urandom_range(3))
          0: put(8'(8'h30 + $urandom_range(9)));
          1: put($urandom_range(1) ? CH_USCORE : CH_DOT);
          default: put(rnd_letter());
        endcase
      end
    endcase
  endtask

  // one scan: mostly well-formed tokens, some deep nesting, some noise
  task automatic queue_scan();
    int kind;
    kind = $urandom_range(99);
    open_scan = 1'b1;
    if (kind < 3) begin
      put(rnd_ident_start());
      repeat (DEPTH_LIMIT - 2 + $urandom_range(4)) put(CH_LT);
      put(CH_NUL);
    end else if (kind < 80) begin
      if ($urandom_range(4) == 0) repeat ($urandom_range(2, 1)) put(rnd_space());
      case ($urandom_range(9))
        0: put(rnd_single());
        1: put(CH_MINUS);
        2: put(CH_QUOTE);
        default: put(rnd_ident_start());
      endcase
      repeat ($urandom_range(7)) put_body_piece();
      case ($urandom_range(7))
        0: put(CH_NUL);
        1: begin
          repeat ($urandom_range(3, 1)) put(rnd_space());
          put(CH_COLON);
        end
        2: begin
          repeat ($urandom_range(2)) put(rnd_space());
          put(rnd_ident_start());
        end
        3: put(CH_GT);
        4: put(delim_reg != 8'h00 ? delim_reg : CH_NUL);
        5: begin
          put(CH_BSLASH);
          put(CH_NUL);
        end
        6: put(8'($urandom_range(255)));
        default: put(CH_LF);
      endcase
    end else if (kind < 95) begin
      put(8'($urandom_range(255)));
      repeat ($urandom_range(5)) put_raw(8'($urandom_range(255)), $urandom_range(7) == 0);
    end else begin
      // stray bytes between scans are ignored and do not count
      repeat ($urandom_range(2, 1)) begin
        put_raw(8'($urandom_range(255)), 1'b0);
        bytes_queued--;
      end
    end
  endtask

  // short directed list: errors at start, single tokens, escapes, nesting
  task automatic queue_directed();
    put_raw(8'h61, 1'b0);
    put_raw(CH_LBRACE, 1'b1);
    put_raw(CH_NUL, 1'b1);
    put_raw(CH_LF, 1'b1);
    put_raw(8'h23, 1'b1);
    put_raw(8'hFF, 1'b1);
    put_raw(CH_SPACE, 1'b1);
    put_raw(8'h61, 1'b0);
    put_raw(8'h62, 1'b0);
    put_raw(CH_BSLASH, 1'b0);
    put_raw(CH_NUL, 1'b0);
    put_raw(8'h78, 1'b1);
    put_raw(CH_LT, 1'b0);
    put_raw(8'h79, 1'b0);
    put_raw(CH_GT, 1'b0);
    put_raw(CH_SPACE, 1'b0);
    put_raw(CH_COLON, 1'b0);
    put_raw(8'h61, 1'b1);
    put_raw(CH_LT, 1'b0);
    put_raw(CH_NUL, 1'b0);
    put_raw(8'h71, 1'b1);
    put_raw(CH_BTICK, 1'b1);
    put_raw(CH_QUOTE, 1'b1);
    put_raw(CH_SPACE, 1'b0);
    put_raw(CH_QUOTE, 1'b0);
    put_raw(CH_RBRACK, 1'b0);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DELIMITER) delim_reg = val;
    else ident_reg = val[0];
  endtask

  task automatic settle();
    while (pending_chars.size() != 0 || char_valid || expected_tokens.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // test sequence: eight phases, each with its own settings and idling
  initial begin
    int seg;
    logic [7:0] delim_plan [8];
    delim_plan = '{8'h00, 8'hFF, CH_COMMA, CH_DOT, CH_LT, 8'h00, 8'h65, 8'h00};
    delim_plan[5] = 8'($urandom_range(255));
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (seg = 0; seg < 8; seg++) begin
      write_reg(CFG_DELIMITER, delim_plan[seg]);
      write_reg(CFG_IDENT_MODE, 8'(seg[0]));
      @(posedge clk);
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      if (seg == 0) begin
        queue_directed();
      end
      if (seg % 4 == 0) hold_requests++;
      bytes_queued = 0;
      while (bytes_queued < SEG_ITEMS) queue_scan();
      settle();
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
